FILE: sv/jrt_pkg.sv
// Shared types, operation codes and the sequence compare for the revoke table.
// No dependencies; every other file in sv/ imports this package.
`default_nettype none

package jrt_pkg;

	localparam int ENTRIES_DEF = 64;

	localparam logic [1:0] OP_SET   = 2'd0;
	localparam logic [1:0] OP_TEST  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] block_number;
		logic [31:0] sequence_req;
	} req_t;

	typedef struct packed {
		logic revoked;
		logic found;
		logic dropped;
	} rsp_t;

	// One stored table entry.
	typedef struct packed {
		logic [63:0] blk;
		logic [31:0] seq;
	} entry_t;

	// Resolution of one request, handed to the output register.
	typedef struct packed {
		logic valid;
		rsp_t rsp;
	} fin_t;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} scan_state_t;

	// True when a is not older than b under 32-bit wraparound.
	function automatic logic seq_not_older(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] diff;
		diff = a - b;
		return ~diff[31];
	endfunction

endpackage

`default_nettype wire

FILE: sv/journal_revoke_table.sv
// Top level of the journal revoke table: entry store, scan sequencer and
// the result register. Depends on jrt_pkg, jrt_mem and jrt_scan.
`default_nettype none

// A request is taken on a rising edge with start high and busy low. Clear
// (and the unused operation code) never raises busy: its all-zero result
// appears on rsp with done high in the following cycle. Set and test scan
// the stored entries in order through the single read port of the entry
// store, one entry a cycle, and busy stays high until the scan has found
// the block or passed the last filled entry; the result shows with done
// high in the first cycle that busy is low. The result is held for exactly
// one cycle with done high; the receiver must take it then, as nothing
// here waits for it. A new request may be given in the same cycle that
// done is high. The store is not cleared after reset: the fill count alone
// marks which entries hold data, so the block is ready as soon as reset is
// released.
module journal_revoke_table #(
	parameter int ENTRIES = jrt_pkg::ENTRIES_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	output logic           busy,
	input  jrt_pkg::req_t  req,
	output logic           done,
	output jrt_pkg::rsp_t  rsp
);
	import jrt_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);

	logic              mem_re, mem_we;
	logic [IDX_W-1:0]  mem_raddr, mem_waddr;
	entry_t            mem_rdata, mem_wdata;
	fin_t              fin;

	logic              done_q;
	rsp_t              rsp_q;

	// entry store: block numbers with their revoking sequence
	jrt_mem #(
		.ENTRIES(ENTRIES)
	) u_mem (
		.clk   (clk),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata)
	);

	// lookup, update and append; answers once per request
	jrt_scan #(
		.ENTRIES(ENTRIES)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.fin       (fin)
	);

	// register each result, shown for one cycle by done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.valid) begin
			rsp_q <= fin.rsp;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

FILE: sv/jrt_mem.sv
// Entry store of the revoke table: one write port, one read port with
// registered read data. Depends on jrt_pkg.
`default_nettype none

module jrt_mem #(
	parameter int ENTRIES = jrt_pkg::ENTRIES_DEF,
	localparam int IDX_W = $clog2(ENTRIES)
) (
	input  wire                  clk,
	input  wire                  re,
	input  wire  [IDX_W-1:0]     raddr,
	output jrt_pkg::entry_t      rdata,
	input  wire                  we,
	input  wire  [IDX_W-1:0]     waddr,
	input  jrt_pkg::entry_t      wdata
);
	import jrt_pkg::*;

	entry_t mem_q [ENTRIES];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: sv/jrt_scan.sv
// Scan sequencer of the revoke table: fill count, linear lookup in the entry
// store, read-modify-write of a match, append on miss. Depends on jrt_pkg.
`default_nettype none

module jrt_scan #(
	parameter int ENTRIES = jrt_pkg::ENTRIES_DEF,
	localparam int IDX_W = $clog2(ENTRIES),
	localparam int CNT_W = $clog2(ENTRIES + 1)
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  jrt_pkg::req_t        req,
	output logic                 busy,
	output logic                 mem_re,
	output logic [IDX_W-1:0]     mem_raddr,
	input  jrt_pkg::entry_t      mem_rdata,
	output logic                 mem_we,
	output logic [IDX_W-1:0]     mem_waddr,
	output jrt_pkg::entry_t      mem_wdata,
	output jrt_pkg::fin_t        fin
);
	import jrt_pkg::*;

	scan_state_t       state_q, state_d;
	req_t              req_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic [IDX_W-1:0]  idx_s1;
	logic              vld_s1;

	logic accept, lookup_op, issue, hit, last, miss, full;

	assign full      = (count_q == CNT_W'(ENTRIES));
	assign accept    = start && (state_q == S_IDLE);
	assign lookup_op = (req.operation == OP_SET) || (req.operation == OP_TEST);
	assign busy      = (state_q != S_IDLE);
	assign issue     = (state_q == S_SCAN) && (idx_q < count_q);
	assign mem_re    = issue;
	assign mem_raddr = idx_q[IDX_W-1:0];
	assign hit       = (state_q == S_SCAN) && vld_s1 && (mem_rdata.blk == req_q.block_number);
	assign last      = vld_s1 && ((CNT_W'(idx_s1) + CNT_W'(1)) == count_q);
	assign miss      = (state_q == S_SCAN) && !hit && ((count_q == '0) || last);

	always_comb begin
		state_d   = state_q;
		fin       = '0;
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = '{blk: req_q.block_number, seq: req_q.sequence_req};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (lookup_op) begin
						state_d = S_SCAN;
					end else begin
						// clear and the unused code answer at once with all zeros
						fin.valid = 1'b1;
					end
				end
			end
			S_SCAN: begin
				if (hit) begin
					state_d       = S_IDLE;
					fin.valid     = 1'b1;
					fin.rsp.found = 1'b1;
					if (req_q.operation == OP_SET) begin
						mem_we = seq_not_older(req_q.sequence_req, mem_rdata.seq);
					end else begin
						fin.rsp.revoked = seq_not_older(mem_rdata.seq, req_q.sequence_req);
					end
				end else if (miss) begin
					state_d   = S_IDLE;
					fin.valid = 1'b1;
					if (req_q.operation == OP_SET) begin
						if (full) begin
							fin.rsp.dropped = 1'b1;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = count_q[IDX_W-1:0];
						end
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (accept) begin
				idx_q  <= '0;
				vld_s1 <= 1'b0;
				if (req.operation == OP_CLEAR) begin
					count_q <= '0;
				end
			end else begin
				vld_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (miss && (req_q.operation == OP_SET) && !full) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		idx_s1 <= idx_q[IDX_W-1:0];
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("fill count beyond table size");

	a_fin_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fin.valid |=> (state_q == S_IDLE))
		else $error("sequencer busy after resolving a request");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SCAN) && vld_s1) |-> (CNT_W'(idx_s1) < count_q))
		else $error("compared an entry beyond the fill count");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(fin.valid && fin.rsp.dropped) |-> full)
		else $error("set dropped while space remained");

endmodule

`default_nettype wire
